/* design/vlqd_pkg.sv */
// Shared types and constants for the length-prefixed deframer.
// No dependencies; imported by the interfaces and every module.
package vlqd_pkg;

   localparam int BYTE_W      = 8;
   localparam int FRAME_LEN_W = 32;
   localparam int DIGIT_W     = 7;

   typedef enum logic [1:0] {
      PH_HDR_FIRST = 2'd0,
      PH_HDR_MORE  = 2'd1,
      PH_PAYLOAD   = 2'd2,
      PH_HALT      = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD    = 2'd0,
      KIND_EMPTY      = 2'd1,
      KIND_OVERFLOW   = 2'd2,
      KIND_OVER_LIMIT = 2'd3
   } kind_type;

   typedef struct packed {
      logic                   valid;
      kind_type               kind;
      logic [BYTE_W-1:0]      out_byte;
      logic                   first_of_frame;
      logic                   last_of_frame;
      logic [FRAME_LEN_W-1:0] frame_length;
   } rsp_beat_type;

endpackage

/* design/vlqd_if.sv */
// Valid/ready channel interfaces: raw byte input, deframed result output,
// and the max_length write port. Depends on vlqd_pkg.
interface vlqd_req_if import vlqd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface vlqd_rsp_if import vlqd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   kind_type               kind;
   logic [BYTE_W-1:0]      out_byte;
   logic                   first_of_frame;
   logic                   last_of_frame;
   logic [FRAME_LEN_W-1:0] frame_length;

   modport source (output valid, output kind, output out_byte, output first_of_frame,
                   output last_of_frame, output frame_length, input ready);
   modport sink   (input valid, input kind, input out_byte, input first_of_frame,
                   input last_of_frame, input frame_length, output ready);
endinterface

interface vlqd_csr_if import vlqd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FRAME_LEN_W-1:0] max_length;

   modport source (output valid, output max_length, input ready);
   modport sink   (input valid, input max_length, output ready);
endinterface

/* design/vlqd_step.sv */
// Per-byte next-state and result logic of the deframer (combinational).
// Depends on vlqd_pkg; instantiated by vlq_length_prefix_deframer.
module vlqd_step
   import vlqd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input  phase_type               phase,
   input  logic [LENGTH_BITS-1:0]  acc,
   input  logic [LENGTH_BITS-1:0]  remaining,
   input  logic                    at_start,
   input  logic [FRAME_LEN_W-1:0]  max_length,
   input  logic [BYTE_W-1:0]       in_byte,
   output phase_type               phase_nxt,
   output logic [LENGTH_BITS-1:0]  acc_nxt,
   output logic [LENGTH_BITS-1:0]  remaining_nxt,
   output logic                    at_start_nxt,
   output rsp_beat_type            beat
);

   localparam int CMP_W = (LENGTH_BITS > FRAME_LEN_W) ? LENGTH_BITS : FRAME_LEN_W;

   logic [LENGTH_BITS-1:0] hdr_acc;
   logic [LENGTH_BITS-1:0] inc_acc;
   logic [LENGTH_BITS-1:0] rem_dec;
   logic                   more;
   logic                   overflow;
   logic                   over_limit;
   logic                   last;

   // Bijective base-128: shift in the digit, add one when a continuation follows.
   assign hdr_acc = (phase == PH_HDR_FIRST) ? LENGTH_BITS'(in_byte[DIGIT_W-1:0])
                  : {acc[LENGTH_BITS-DIGIT_W-1:0], in_byte[DIGIT_W-1:0]};
   assign inc_acc    = hdr_acc + LENGTH_BITS'(1);
   assign more       = in_byte[BYTE_W-1];
   assign overflow   = (inc_acc == '0) || (inc_acc[LENGTH_BITS-1 -: DIGIT_W] != '0);
   assign over_limit = (max_length != '0) && (CMP_W'(hdr_acc) > CMP_W'(max_length));
   assign last       = (remaining <= LENGTH_BITS'(1));
   assign rem_dec    = (remaining != '0) ? remaining - LENGTH_BITS'(1) : remaining;

   always_comb begin
      phase_nxt     = phase;
      acc_nxt       = acc;
      remaining_nxt = remaining;
      at_start_nxt  = at_start;
      case (phase)
         PH_HALT: begin
         end
         PH_PAYLOAD: begin
            at_start_nxt  = 1'b0;
            remaining_nxt = rem_dec;
            if (last) begin
               phase_nxt    = PH_HDR_FIRST;
               at_start_nxt = 1'b1;
               acc_nxt      = '0;
            end
         end
         PH_HDR_FIRST, PH_HDR_MORE: begin
            if (more) begin
               acc_nxt   = inc_acc;
               phase_nxt = overflow ? PH_HALT : PH_HDR_MORE;
            end else if (over_limit) begin
               acc_nxt   = hdr_acc;
               phase_nxt = PH_HALT;
            end else if (hdr_acc == '0) begin
               acc_nxt      = '0;
               at_start_nxt = 1'b1;
               phase_nxt    = PH_HDR_FIRST;
            end else begin
               acc_nxt       = hdr_acc;
               remaining_nxt = hdr_acc;
               at_start_nxt  = 1'b1;
               phase_nxt     = PH_PAYLOAD;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      beat = '{valid: 1'b0, kind: KIND_PAYLOAD, out_byte: '0, first_of_frame: 1'b0,
               last_of_frame: 1'b0, frame_length: '0};
      case (phase)
         PH_HALT: begin
         end
         PH_PAYLOAD: begin
            beat.valid          = 1'b1;
            beat.out_byte       = in_byte;
            beat.first_of_frame = at_start;
            beat.last_of_frame  = last;
            beat.frame_length   = FRAME_LEN_W'(acc);
         end
         PH_HDR_FIRST, PH_HDR_MORE: begin
            if (more) begin
               if (overflow) begin
                  beat.valid = 1'b1;
                  beat.kind  = KIND_OVERFLOW;
               end
            end else if (over_limit) begin
               beat.valid        = 1'b1;
               beat.kind         = KIND_OVER_LIMIT;
               beat.frame_length = FRAME_LEN_W'(hdr_acc);
            end else if (hdr_acc == '0) begin
               beat.valid         = 1'b1;
               beat.kind          = KIND_EMPTY;
               beat.last_of_frame = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

/* design/vlq_length_prefix_deframer.sv */
// Length-prefixed byte stream deframer: one raw byte per beat in, payload
// bytes, empty-frame and error results out. Depends on vlqd_pkg, vlqd_if, vlqd_step.
// A result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while rsp is not stalled; the single output register
// accepts a new beat in the same cycle its held result is taken.
// Reset: synchronous; returns to header phase, clears the output and max_length.
module vlq_length_prefix_deframer
   import vlqd_pkg::*;
#(
   parameter int LENGTH_BITS = 32
) (
   input logic       clock,
   input logic       reset,
   vlqd_req_if.sink  req,
   vlqd_rsp_if.source rsp,
   vlqd_csr_if.sink  csr
);

   phase_type              phase_ff, phase_in;
   logic [LENGTH_BITS-1:0] acc_ff, acc_in;
   logic [LENGTH_BITS-1:0] remaining_ff, remaining_in;
   logic                   at_start_ff, at_start_in;
   logic [FRAME_LEN_W-1:0] max_length_ff;
   rsp_beat_type           rsp_ff, rsp_in;
   rsp_beat_type           beat;
   logic                   accept;

   vlqd_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
      .phase         (phase_ff),
      .acc           (acc_ff),
      .remaining     (remaining_ff),
      .at_start      (at_start_ff),
      .max_length    (max_length_ff),
      .in_byte       (req.in_byte),
      .phase_nxt     (phase_in),
      .acc_nxt       (acc_in),
      .remaining_nxt (remaining_in),
      .at_start_nxt  (at_start_in),
      .beat          (beat)
   );

   // Take a new byte whenever the output slot is empty or drains this cycle.
   assign req.ready = !rsp_ff.valid || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   always_comb begin
      rsp_in = rsp_ff;
      if (rsp_ff.valid && rsp.ready) begin
         rsp_in.valid = 1'b0;
      end
      if (accept && beat.valid) begin
         rsp_in = beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HDR_FIRST;
         acc_ff        <= '0;
         remaining_ff  <= '0;
         at_start_ff   <= 1'b1;
         max_length_ff <= '0;
         rsp_ff        <= '0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            acc_ff       <= acc_in;
            remaining_ff <= remaining_in;
            at_start_ff  <= at_start_in;
         end
         if (csr.valid) begin
            max_length_ff <= csr.max_length;
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid          = rsp_ff.valid;
   assign rsp.kind           = rsp_ff.kind;
   assign rsp.out_byte       = rsp_ff.out_byte;
   assign rsp.first_of_frame = rsp_ff.first_of_frame;
   assign rsp.last_of_frame  = rsp_ff.last_of_frame;
   assign rsp.frame_length   = rsp_ff.frame_length;

endmodule

/* verif/vlq_length_prefix_deframer_test.sv */
// Self-checking bench for vlq_length_prefix_deframer: drives framed byte streams,
// predicts every deframed beat and compares it. Depends on vlqd_pkg and vlqd_if.
`timescale 1ns / 100ps

module vlq_length_prefix_deframer_test;
   import vlqd_pkg::*;

   localparam int          LENGTH_BITS     = 32;
   localparam logic [63:0] LEN_MASK        = {64{1'b1}} >> (64 - LENGTH_BITS);
   localparam int          ITEMS_PER_MIX   = 415;
   localparam int          WATCHDOG_CYCLES = 2000;
   localparam int          TRAILING_NOISE  = 12;

   typedef enum int {
      END_OVERFLOW   = 0,
      END_WRAP       = 1,
      END_OVER_LIMIT = 2
   } ending_type;

   typedef struct packed {
      kind_type               kind;
      logic [BYTE_W-1:0]      out_byte;
      logic                   first_of_frame;
      logic                   last_of_frame;
      logic [FRAME_LEN_W-1:0] frame_length;
   } deframed_beat_type;

   logic clock;
   logic reset;

   vlqd_req_if req_bus ();
   vlqd_rsp_if rsp_bus ();
   vlqd_csr_if csr_bus ();

   vlq_length_prefix_deframer #(
      .LENGTH_BITS(LENGTH_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_bus),
      .rsp  (rsp_bus),
      .csr  (csr_bus)
   );

   // stream still to be driven and beats still to arrive
   logic [BYTE_W-1:0] raw_stream[$];
   deframed_beat_type deframed_beats[$];

   // shadow of the deframer state
   phase_type              parse_phase;
   logic [63:0]            len_acc;
   logic [63:0]            remaining;
   logic                   at_start;
   logic [FRAME_LEN_W-1:0] limit;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int bytes_queued       = 0;
   int bytes_taken        = 0;
   int results_checked    = 0;
   int fail_count         = 0;
   int quiet_cycles       = 0;
   bit req_beat_taken     = 1'b0;
   bit csr_accepted       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic deframe_byte(input logic [BYTE_W-1:0] b,
                                         output deframed_beat_type beat);
      logic [63:0] acc;
      beat = '{kind: KIND_PAYLOAD, out_byte: '0, first_of_frame: 1'b0,
               last_of_frame: 1'b0, frame_length: '0};
      deframe_byte = 1'b0;
      case (parse_phase)
         PH_HALT: begin
            deframe_byte = 1'b0;
         end
         PH_PAYLOAD: begin
            beat.out_byte       = b;
            beat.first_of_frame = at_start;
            beat.last_of_frame  = (remaining <= 1);
            beat.frame_length   = len_acc[FRAME_LEN_W-1:0];
            at_start = 1'b0;
            if (remaining != 0) remaining = remaining - 1;
            if (remaining == 0) begin
               parse_phase = PH_HDR_FIRST;
               at_start    = 1'b1;
               len_acc     = '0;
            end
            deframe_byte = 1'b1;
         end
         default: begin
            if (parse_phase == PH_HDR_FIRST) acc = {57'h0, b[DIGIT_W-1:0]};
            else acc = ((len_acc << DIGIT_W) | b[DIGIT_W-1:0]) & LEN_MASK;
            if (b[BYTE_W-1]) begin
               // continuation digit: bump, then check the headroom for one more digit
               acc     = (acc + 1) & LEN_MASK;
               len_acc = acc;
               if (acc == 0 || (acc >> (LENGTH_BITS - DIGIT_W)) != 0) begin
                  parse_phase  = PH_HALT;
                  beat.kind    = KIND_OVERFLOW;
                  deframe_byte = 1'b1;
               end else begin
                  parse_phase = PH_HDR_MORE;
               end
            end else begin
               len_acc = acc;
               if (limit != 0 && acc > {32'h0, limit}) begin
                  parse_phase       = PH_HALT;
                  beat.kind         = KIND_OVER_LIMIT;
                  beat.frame_length = acc[FRAME_LEN_W-1:0];
                  deframe_byte      = 1'b1;
               end else if (acc == 0) begin
                  parse_phase        = PH_HDR_FIRST;
                  at_start           = 1'b1;
                  beat.kind          = KIND_EMPTY;
                  beat.last_of_frame = 1'b1;
                  deframe_byte       = 1'b1;
               end else begin
                  remaining   = acc;
                  at_start    = 1'b1;
                  parse_phase = PH_PAYLOAD;
               end
            end
         end
      endcase
   endfunction

   // monitor: predict on accepted bytes, check accepted results, watch for a hang
   always @(posedge clock) begin
      deframed_beat_type beat;
      deframed_beat_type want;
      bit                moved;
      if (reset) begin
         parse_phase = PH_HDR_FIRST;
         len_acc     = '0;
         remaining   = '0;
         at_start    = 1'b1;
         limit       = '0;
      end else begin
         moved = 1'b0;
         if (csr_bus.valid && csr_bus.ready) begin
            limit        = csr_bus.max_length;
            csr_accepted = 1'b1;
            moved        = 1'b1;
         end
         if (req_bus.valid && req_bus.ready) begin
            if (deframe_byte(req_bus.in_byte, beat)) deframed_beats.push_back(beat);
            bytes_taken++;
            req_beat_taken = 1'b1;
            moved          = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            results_checked++;
            if (deframed_beats.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected result: kind %0d byte %02h first %b last %b len %0d",
                           $time, rsp_bus.kind, rsp_bus.out_byte, rsp_bus.first_of_frame,
                           rsp_bus.last_of_frame, rsp_bus.frame_length);
            end else begin
               want = deframed_beats.pop_front();
               if (want.kind !== rsp_bus.kind || want.out_byte !== rsp_bus.out_byte ||
                   want.first_of_frame !== rsp_bus.first_of_frame ||
                   want.last_of_frame !== rsp_bus.last_of_frame ||
                   want.frame_length !== rsp_bus.frame_length) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: mismatch: expected kind %0d byte %02h first %b last %b len %0d",
                              $time, want.kind, want.out_byte, want.first_of_frame,
                              want.last_of_frame, want.frame_length);
                     $display("%0t:           actual   kind %0d byte %02h first %b last %b len %0d",
                              $time, rsp_bus.kind, rsp_bus.out_byte, rsp_bus.first_of_frame,
                              rsp_bus.last_of_frame, rsp_bus.frame_length);
                  end
               end
            end
         end
         if (moved) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_CYCLES) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // driver: new byte only once the held one is taken; random receiver stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_bus.valid || req_beat_taken) begin
            if (raw_stream.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
               req_bus.in_byte <= raw_stream.pop_front();
               req_bus.valid   <= 1'b1;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
         req_beat_taken = 1'b0;
         rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      raw_stream.push_back(b);
      bytes_queued++;
   endtask

   // bijective base-128 header, most significant digit first
   task automatic push_header(input logic [63:0] len, input bit tail_continues);
      logic [BYTE_W-1:0] digits[$];
      logic [63:0]       rest;
      digits.push_front({tail_continues, len[DIGIT_W-1:0]});
      rest = len >> DIGIT_W;
      while (rest != 0) begin
         rest = rest - 1;
         digits.push_front({1'b1, rest[DIGIT_W-1:0]});
         rest = rest >> DIGIT_W;
      end
      foreach (digits[i]) push_byte(digits[i]);
   endtask

   task automatic push_frame(input logic [63:0] len);
      push_header(len, 1'b0);
      repeat (len) push_byte($urandom_range(0, 255));
   endtask

   // mostly short frames, some around the one/two digit header boundary
   function automatic logic [63:0] pick_length(input logic [FRAME_LEN_W-1:0] cap);
      int          r;
      logic [63:0] len;
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 80) len = $urandom_range(1, 16);
      else if (r < 92) len = $urandom_range(17, 64);
      else len = $urandom_range(120, 136);
      if (cap != 0 && len > cap) len = cap;
      return len;
   endfunction

   task automatic fill_frames(input int count, input logic [FRAME_LEN_W-1:0] cap);
      int start;
      start = bytes_queued;
      while (bytes_queued - start < count) push_frame(pick_length(cap));
   endtask

   // hold until every byte is taken and every predicted beat has arrived
   task automatic drain();
      while (raw_stream.size() != 0 || bytes_taken != bytes_queued || deframed_beats.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_max_length(input logic [FRAME_LEN_W-1:0] value);
      @(negedge clock);
      csr_accepted = 1'b0;
      csr_bus.max_length <= value;
      csr_bus.valid      <= 1'b1;
      do @(negedge clock); while (!csr_accepted);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      ending_type             ending;
      logic [FRAME_LEN_W-1:0] cap;
      logic [63:0]            len;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.in_byte    = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.max_length = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty frames, payload extremes, then a limit of one
      write_max_length('0);
      push_header(0, 1'b0);
      push_header(1, 1'b0);
      push_byte(8'hff);
      push_header(2, 1'b0);
      push_byte(8'h00);
      push_byte(8'h80);
      push_header(0, 1'b0);
      push_header(3, 1'b0);
      push_byte(8'h7f);
      push_byte(8'h01);
      push_byte(8'hfe);
      drain();
      write_max_length(32'd1);
      push_header(1, 1'b0);
      push_byte(8'h55);
      push_header(0, 1'b0);
      push_header(1, 1'b0);
      push_byte(8'haa);
      drain();

      for (int mix = 0; mix < 4; mix++) begin
         case (mix)
            0: begin
               sender_idle_pct = 0;  receiver_stall_pct = 0;  cap = 32'hffff_ffff;
            end
            1: begin
               sender_idle_pct = 51; receiver_stall_pct = 0;  cap = $urandom_range(130, 400);
            end
            2: begin
               sender_idle_pct = 0;  receiver_stall_pct = 51; cap = '0;
            end
            default: begin
               sender_idle_pct = 23; receiver_stall_pct = 23; cap = $urandom;
            end
         endcase
         write_max_length(cap);
         fill_frames(ITEMS_PER_MIX, cap);
         drain();
      end

      // one fatal header ends the run: the block stays halted from then on
      ending = ending_type'($urandom_range(0, 2));
      case (ending)
         END_OVERFLOW: begin
            fill_frames(30, cap);
            // five continuation digits always overflow the accumulator
            repeat (5) push_byte($urandom_range(128, 255));
         end
         END_WRAP: begin
            push_header(64'hffff_ffff, 1'b1);
         end
         default: begin
            cap = $urandom_range(1, 32'hffff_fffe);
            write_max_length(cap);
            len = $urandom_range(cap + 1, 32'hffff_ffff);
            push_header(len, 1'b0);
         end
      endcase
      repeat (TRAILING_NOISE) push_byte($urandom_range(0, 255));
      drain();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      repeat (8) @(negedge clock);

      $display("deframer run: %0d bytes in, %0d results checked across four idle mixes",
               bytes_taken, results_checked);
      $display("limits covered: none, one, all ones, random; run closed by %s",
               ending.name());
      if (fail_count == 0 && deframed_beats.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* vlq_length_prefix_deframer.f */
design/vlqd_pkg.sv
design/vlqd_if.sv
design/vlqd_step.sv
design/vlq_length_prefix_deframer.sv
verif/vlq_length_prefix_deframer_test.sv
